### hdl/sdta_pkg.sv
// Shared types and constants for the signed decimal to ASCII unit.
`default_nettype none

package sdta_pkg;

   localparam int VALUE_W         = 64;
   localparam int DIGIT_W         = 4;
   localparam int NUM_DIGITS      = 20;
   localparam int BCD_W           = NUM_DIGITS * DIGIT_W;
   localparam int IDX_W           = $clog2(NUM_DIGITS);
   localparam int STEPS_PER_CYCLE = 4;
   localparam int SHIFT_CYCLES    = VALUE_W / STEPS_PER_CYCLE;
   localparam int STEP_W          = $clog2(SHIFT_CYCLES);
   localparam int CHAR_W          = 8;
   localparam int COUNT_W         = 31;

   localparam logic [COUNT_W-1:0] COUNT_MAX  = {COUNT_W{1'b1}};
   localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0]  CHAR_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0]  CHAR_MINUS = 8'h2D;

   typedef logic [BCD_W-1:0] bcd_type;

   // One converted number waiting to be printed.
   typedef struct packed {
      logic             neg;
      logic [IDX_W-1:0] top_idx;
      bcd_type          digits;
   } entry_type;

   typedef enum logic [1:0] {
      CV_IDLE,
      CV_SHIFT,
      CV_PUSH
   } conv_state_type;

endpackage

`default_nettype wire

### hdl/sdta_convert.sv
// Front end: takes a signed value, forms its magnitude and converts it to BCD.
`default_nettype none

module sdta_convert (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_ready,
   input  wire signed [sdta_pkg::VALUE_W-1:0]   req_value,
   output logic                                 push_valid,
   input  wire                                  push_ready,
   output sdta_pkg::entry_type                  push_entry
);
   import sdta_pkg::*;

   conv_state_type     state_ff, state_in;
   logic [VALUE_W-1:0] mag_ff, mag_in;
   bcd_type            bcd_ff, bcd_in, bcd_next;
   logic               neg_ff, neg_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [VALUE_W-1:0] raw;
   logic [IDX_W-1:0]   top_idx;

   // One shift-add-3 step: correct every digit, then shift in the next bit.
   function automatic bcd_type dabble(input bcd_type b, input logic bit_in);
      bcd_type            adj;
      logic [DIGIT_W-1:0] dig;
      for (int d = 0; d < NUM_DIGITS; d++) begin
         dig = b[d*DIGIT_W +: DIGIT_W];
         adj[d*DIGIT_W +: DIGIT_W] = (dig >= 4'd5) ? dig + 4'd3 : dig;
      end
      return {adj[BCD_W-2:0], bit_in};
   endfunction

   assign raw = req_value;

   always_comb begin
      bcd_next = bcd_ff;
      for (int s = 0; s < STEPS_PER_CYCLE; s++) begin
         bcd_next = dabble(bcd_next, mag_ff[VALUE_W-1-s]);
      end
   end

   // Position of the leading nonzero digit; zero prints one digit.
   always_comb begin
      top_idx = '0;
      for (int d = 0; d < NUM_DIGITS; d++) begin
         if (bcd_ff[d*DIGIT_W +: DIGIT_W] != '0) begin
            top_idx = IDX_W'(d);
         end
      end
   end

   always_comb begin
      state_in   = state_ff;
      mag_in     = mag_ff;
      bcd_in     = bcd_ff;
      neg_in     = neg_ff;
      step_in    = step_ff;
      req_ready  = 1'b0;
      push_valid = 1'b0;
      unique case (state_ff)
         CV_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               neg_in   = raw[VALUE_W-1];
               mag_in   = raw[VALUE_W-1] ? (~raw + {{(VALUE_W-1){1'b0}}, 1'b1}) : raw;
               bcd_in   = '0;
               step_in  = '0;
               state_in = CV_SHIFT;
            end
         end
         CV_SHIFT: begin
            bcd_in  = bcd_next;
            mag_in  = mag_ff << STEPS_PER_CYCLE;
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(SHIFT_CYCLES - 1)) begin
               state_in = CV_PUSH;
            end
         end
         CV_PUSH: begin
            push_valid = 1'b1;
            if (push_ready) begin
               state_in = CV_IDLE;
            end
         end
         default: begin
            state_in = CV_IDLE;
         end
      endcase
   end

   always_comb begin
      push_entry.neg     = neg_ff;
      push_entry.top_idx = top_idx;
      push_entry.digits  = bcd_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CV_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff  <= mag_in;
      bcd_ff  <= bcd_in;
      neg_ff  <= neg_in;
      step_ff <= step_in;
   end

endmodule

`default_nettype wire

### hdl/sdta_fifo.sv
// Short queue of converted numbers between the converter and the emitter.
`default_nettype none

module sdta_fifo #(
   parameter int DEPTH = 2
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  push_valid,
   output logic                 push_ready,
   input  wire sdta_pkg::entry_type push_entry,
   output logic                 pop_valid,
   input  wire                  pop_ready,
   output sdta_pkg::entry_type  pop_entry
);
   import sdta_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type        slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? advance(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? advance(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

### hdl/sdta_emit.sv
// Back end: prints one queued number as ASCII, one character per beat.
`default_nettype none

module sdta_emit (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                pop_valid,
   output logic                               pop_ready,
   input  wire sdta_pkg::entry_type           pop_entry,
   output logic                               rsp_valid,
   input  wire                                rsp_ready,
   output logic [sdta_pkg::CHAR_W-1:0]        rsp_out_char,
   output logic                               rsp_last_char,
   output logic [sdta_pkg::COUNT_W-1:0]       rsp_total_emitted
);
   import sdta_pkg::*;

   logic               busy_ff, busy_in;
   logic               neg_ff, neg_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   bcd_type            digits_ff, digits_in;
   logic [COUNT_W-1:0] count_ff, count_in, count_next;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]  char_ff, char_in;
   logic               last_ff, last_in;
   logic [COUNT_W-1:0] total_ff, total_in;
   logic [DIGIT_W-1:0] cur_digit;
   logic               load;

   assign pop_ready  = !busy_ff;
   assign load       = busy_ff && (!rsp_valid_ff || rsp_ready);
   assign cur_digit  = digits_ff[idx_ff*DIGIT_W +: DIGIT_W];
   assign count_next = (count_ff == COUNT_MAX) ? count_ff : count_ff + COUNT_W'(1);

   always_comb begin
      busy_in      = busy_ff;
      neg_in       = neg_ff;
      idx_in       = idx_ff;
      digits_in    = digits_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      char_in      = char_ff;
      last_in      = last_ff;
      total_in     = total_ff;
      if (pop_valid && pop_ready) begin
         busy_in   = 1'b1;
         neg_in    = pop_entry.neg;
         idx_in    = pop_entry.top_idx;
         digits_in = pop_entry.digits;
      end
      if (load) begin
         rsp_valid_in = 1'b1;
         count_in     = count_next;
         total_in     = count_next;
         if (neg_ff) begin
            char_in = CHAR_MINUS;
            last_in = 1'b0;
            neg_in  = 1'b0;
         end else begin
            char_in = CHAR_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, cur_digit};
            last_in = (idx_ff == '0);
            if (idx_ff == '0) begin
               busy_in = 1'b0;
            end else begin
               idx_in = idx_ff - IDX_W'(1);
            end
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         neg_ff       <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         neg_ff       <= neg_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      digits_ff <= digits_in;
      char_ff   <= char_in;
      last_ff   <= last_in;
      total_ff  <= total_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_char      = char_ff;
   assign rsp_last_char     = last_ff;
   assign rsp_total_emitted = total_ff;

endmodule

`default_nettype wire

### hdl/signed_decimal_to_ascii_unit.sv
// Top level of the signed decimal to ASCII unit.
//
// Usage:
//   req_value is a signed 64-bit integer, taken when req_valid and req_ready
//   are both high. Its decimal text comes out on the rsp_ channel, one
//   character per beat, most significant digit first, with a leading '-' for
//   negative values. rsp_last_char marks the final character of each number;
//   rsp_total_emitted counts every character since reset, this one included,
//   and sticks at its maximum.
//   The converter runs 4 binary bits per cycle through a BCD shift-add-3
//   chain; each converted number is then queued, popped and loaded into the
//   registered output beat before its first character appears. The
//   converter takes a new number only after handing the last one to the
//   queue; the emitter prints 1 to 20 characters per number, one per beat,
//   and holds a character while the receiver stalls.
//   A queue of QUEUE_DEPTH converted numbers decouples the halves, so the
//   converter keeps working while the receiver stalls. req_ready is high only
//   while the converter is idle, never while it converts or holds a number.
//   Reset (synchronous, active high) empties the queue, idles both halves and
//   clears the character count.
`default_nettype none

module signed_decimal_to_ascii_unit #(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_ready,
   input  wire signed [sdta_pkg::VALUE_W-1:0]   req_value,
   output logic                                 rsp_valid,
   input  wire                                  rsp_ready,
   output logic [sdta_pkg::CHAR_W-1:0]          rsp_out_char,
   output logic                                 rsp_last_char,
   output logic [sdta_pkg::COUNT_W-1:0]         rsp_total_emitted
);
   import sdta_pkg::*;

   // Converter to queue.
   logic      push_valid;
   logic      push_ready;
   entry_type push_entry;

   // Queue to emitter.
   logic      pop_valid;
   logic      pop_ready;
   entry_type pop_entry;

   // Front: accept, take magnitude, convert to BCD, find the leading digit.
   sdta_convert u_convert (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_value  (req_value),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   // Decouple the halves so either side can stall on its own.
   sdta_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   // Back: drive sign and digits out through a registered output beat.
   sdta_emit u_emit (
      .clock             (clock),
      .reset             (reset),
      .pop_valid         (pop_valid),
      .pop_ready         (pop_ready),
      .pop_entry         (pop_entry),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_char      (rsp_out_char),
      .rsp_last_char     (rsp_last_char),
      .rsp_total_emitted (rsp_total_emitted)
   );

`ifndef ASSERT_OFF
   // A sign never ends a number.
   a_minus_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_char == CHAR_MINUS) |-> !rsp_last_char)
      else $error("minus sign marked as last character");

   // Only '-' or a decimal digit comes out.
   a_char_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_out_char == CHAR_MINUS ||
                     (rsp_out_char >= CHAR_ZERO && rsp_out_char <= CHAR_NINE)))
      else $error("illegal output character");

   // Within a number the next character follows without a gap.
   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last_char) |=> rsp_valid)
      else $error("gap inside a number's text");

   // The running count advances by one per character until it saturates.
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_total_emitted != COUNT_MAX) |=>
      (!rsp_valid || rsp_total_emitted == $past(rsp_total_emitted) + COUNT_W'(1)))
      else $error("character count skipped");
`endif

endmodule

`default_nettype wire

### verif/decimal_text_board_pkg.sv
// Scoreboard package: expected decimal text beats for the signed decimal to ASCII unit.
`timescale 1ns / 100ps

package decimal_text_board_pkg;

   import sdta_pkg::*;

   typedef struct packed {
      logic [CHAR_W-1:0]  ch;
      logic               last;
      logic [COUNT_W-1:0] total;
   } text_beat_type;

   class decimal_text_board;
      text_beat_type      pending_chars[$];
      logic [COUNT_W-1:0] chars_emitted;
      int unsigned        errors;
      int unsigned        beats_seen;

      function new();
         chars_emitted = '0;
         errors        = 0;
         beats_seen    = 0;
      endfunction

      // Queue the characters one accepted value should print.
      function void note_value(logic [VALUE_W-1:0] raw);
         logic [VALUE_W-1:0] mag;
         logic [CHAR_W-1:0]  digit_chars[NUM_DIGITS];
         text_beat_type      beat;
         int                 nd;
         nd  = 0;
         mag = raw[VALUE_W-1] ? (~raw + 1'b1) : raw;
         do begin
            digit_chars[nd] = CHAR_ZERO + CHAR_W'(mag % 64'd10);
            nd++;
            mag = mag / 64'd10;
         end while (mag != 0 && nd < NUM_DIGITS);
         if (raw[VALUE_W-1]) begin
            if (chars_emitted != COUNT_MAX) chars_emitted++;
            beat.ch    = CHAR_MINUS;
            beat.last  = 1'b0;
            beat.total = chars_emitted;
            pending_chars.push_back(beat);
         end
         for (int i = nd - 1; i >= 0; i--) begin
            if (chars_emitted != COUNT_MAX) chars_emitted++;
            beat.ch    = digit_chars[i];
            beat.last  = (i == 0);
            beat.total = chars_emitted;
            pending_chars.push_back(beat);
         end
      endfunction

      function void check_char(logic [CHAR_W-1:0] ch, logic last, logic [COUNT_W-1:0] total);
         text_beat_type want;
         beats_seen++;
         if (pending_chars.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("beat %0d: unexpected char %h last %b count %0d",
                        beats_seen, ch, last, total);
            return;
         end
         want = pending_chars.pop_front();
         if (want.ch !== ch || want.last !== last || want.total !== total) begin
            errors++;
            if (errors <= 10)
               $display({"beat %0d: expected char %h last %b count %0d, ",
                         "got char %h last %b count %0d"},
                        beats_seen, want.ch, want.last, want.total, ch, last, total);
         end
      endfunction

      function int unsigned outstanding();
         return pending_chars.size();
      endfunction

      // Count every character still owed as a failure.
      function void close_out();
         if (pending_chars.size() != 0) begin
            errors += pending_chars.size();
            $display("%0d expected characters never arrived", pending_chars.size());
         end
      endfunction
   endclass

endpackage

### verif/tb_signed_decimal_to_ascii_unit.sv
// Testbench top: drives signed values into the decimal to ASCII unit and checks every text beat.
`timescale 1ns / 100ps

module tb_signed_decimal_to_ascii_unit;

   import sdta_pkg::*;
   import decimal_text_board_pkg::*;

   localparam int RANDOM_ITEMS = 320;
   // No beat on either channel for this long means the block is hung. The
   // worst honest quiet stretch is a long sender gap plus conversion plus a
   // long receiver stall, well under IDLE_LIMIT.
   localparam int IDLE_LIMIT   = 3000;
   localparam int DRAIN_CYCLES = 40;

   // Edges of the value range, digit-count boundaries, both alternating bit
   // patterns, and the most negative value whose magnitude does not fit in
   // a signed 64-bit number.
   localparam logic [VALUE_W-1:0] DIRECTED_VALUES [20] = '{
      64'd0,
      64'd1,
      -64'sd1,
      64'd9,
      64'd10,
      -64'sd9,
      -64'sd10,
      64'd99,
      64'd100,
      -64'sd1000,
      64'h7FFF_FFFF_FFFF_FFFF,
      64'h8000_0000_0000_0000,
      64'h8000_0000_0000_0001,
      64'd999999999999999999,
      64'd1000000000000000000,
      -64'sd1000000000000000000,
      64'h5555_5555_5555_5555,
      64'hAAAA_AAAA_AAAA_AAAA,
      64'd123456789,
      -64'sd123456789
   };

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [VALUE_W-1:0]  req_value;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [CHAR_W-1:0]   rsp_out_char;
   logic                rsp_last_char;
   logic [COUNT_W-1:0]  rsp_total_emitted;

   decimal_text_board   board;
   bit                  steady_sender;
   int unsigned         idle_cycles;

   signed_decimal_to_ascii_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_char      (rsp_out_char),
      .rsp_last_char     (rsp_last_char),
      .rsp_total_emitted (rsp_total_emitted)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Mostly short gaps, now and then a long one.
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 35) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [VALUE_W-1:0] power_of_ten(int unsigned exp10);
      logic [VALUE_W-1:0] p;
      p = 64'd1;
      repeat (exp10) p = p * 64'd10;
      return p;
   endfunction

   // Shape random values so every digit count shows up, not just the
   // 19-digit numbers that a flat 64-bit draw nearly always gives.
   function automatic logic [VALUE_W-1:0] random_value();
      logic [VALUE_W-1:0] v;
      int unsigned        roll;
      roll = $urandom_range(0, 99);
      v    = {$urandom(), $urandom()};
      if (roll < 30) begin
         return v;
      end else if (roll < 75) begin
         v = v % power_of_ten($urandom_range(1, 19));
      end else if (roll < 90) begin
         v = power_of_ten($urandom_range(0, 18)) + 64'($urandom_range(0, 2)) - 64'd1;
      end else begin
         // Crowd the ends of the range.
         v = 64'h7FFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 1000));
      end
      if ($urandom_range(0, 1)) v = ~v + 1'b1;
      return v;
   endfunction

   // Call at a falling edge; returns at the falling edge after the beat.
   task automatic send_value(input logic [VALUE_W-1:0] value);
      int unsigned gap;
      gap = steady_sender ? 0 : pick_gap();
      if (gap != 0) begin
         // Drop valid and put noise on the payload while idle.
         req_valid <= 1'b0;
         req_value <= {$urandom(), $urandom()};
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_value <= value;
      do @(posedge clock); while (!req_ready);
      board.note_value(value);
      @(negedge clock);
   endtask

   // Receiver: stretches of ready broken by stalls, some long, plus long
   // runs with no stall at all.
   initial begin
      int unsigned run_len;
      int unsigned stall_len;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         run_len   = ($urandom_range(0, 4) == 0) ? 100 : $urandom_range(1, 20);
         stall_len = pick_gap();
         repeat (run_len) begin
            rsp_ready <= 1'b1;
            @(negedge clock);
         end
         repeat (stall_len) begin
            rsp_ready <= 1'b0;
            @(negedge clock);
         end
      end
   end

   // Check each result beat at the edge that takes it.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_char(rsp_out_char, rsp_last_char, rsp_total_emitted);
   end

   // Watchdog: reset the count on any beat, end the run if it gets too high.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("signed_decimal_to_ascii_unit: mismatch");
         $finish;
      end
   end

   initial begin
      board         = new();
      steady_sender = 1'b0;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_value     = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_VALUES[i]) send_value(DIRECTED_VALUES[i]);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // Switch between gapped and back-to-back stretches now and then.
         if (n % 40 == 0) steady_sender = ($urandom_range(0, 2) == 0);
         send_value(random_value());
      end
      req_valid <= 1'b0;

      // Drain: wait for every owed character, then hold a little longer to
      // catch any extra beat.
      while (board.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      board.close_out();
      if (board.errors == 0)
         $display("signed_decimal_to_ascii_unit: match");
      else
         $display("signed_decimal_to_ascii_unit: mismatch");
      $finish;
   end

endmodule
